[hw/rtl/dcp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and the per-level dragon curve table for the point core.
package dcp_pkg;

	localparam int DCP_LEVELS_DEF = 60;
	localparam int CNT_W          = 60;
	localparam int COORD_W        = 32;
	localparam int CMP_W          = 64;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} dcp_vec_t;

	typedef struct packed {
		dcp_vec_t   a;
		dcp_vec_t   b;
		logic [1:0] ad;
		logic [1:0] bd;
	} dcp_lvl_t;

	typedef struct packed {
		logic [CNT_W-1:0]   n;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [1:0]         d;
		logic               in_b;
		logic               done;
		logic               bad;
	} dcp_walk_t;

	localparam dcp_vec_t UNIT_VEC = '{x: '0, y: COORD_W'(1)};

	// Rotates a vector by the given number of quarter turns clockwise.
	function automatic dcp_vec_t dcp_rot(dcp_vec_t v, logic [1:0] dir);
		dcp_vec_t r;
		case (dir)
			2'd0: begin
				r.x = v.x;
				r.y = v.y;
			end
			2'd1: begin
				r.x = v.y;
				r.y = -v.x;
			end
			2'd2: begin
				r.x = -v.x;
				r.y = -v.y;
			end
			default: begin
				r.x = -v.y;
				r.y = v.x;
			end
		endcase
		return r;
	endfunction

	function automatic dcp_vec_t dcp_add(dcp_vec_t p, dcp_vec_t q);
		dcp_vec_t r;
		r.x = p.x + q.x;
		r.y = p.y + q.y;
		return r;
	endfunction

	// Displacement and net turn of the a and b expansions at level h.
	function automatic dcp_lvl_t dcp_level(int h);
		dcp_lvl_t   t;
		dcp_lvl_t   p;
		logic [1:0] d;
		dcp_vec_t   acc;
		t = '0;
		for (int i = 1; i <= h; i++) begin
			p = t;
			d = p.ad + 2'd1;
			acc = dcp_add(p.a, dcp_rot(p.b, d));
			d = d + p.bd;
			acc = dcp_add(acc, dcp_rot(UNIT_VEC, d));
			d = d + 2'd1;
			t.a = acc;
			t.ad = d;
			acc.x = '1;
			acc.y = '0;
			d = 2'd3;
			acc = dcp_add(acc, dcp_rot(p.a, d));
			d = d + p.ad + 2'd3;
			acc = dcp_add(acc, dcp_rot(p.b, d));
			d = d + p.bd;
			t.b = acc;
			t.bd = d;
		end
		return t;
	endfunction

endpackage

[hw/rtl/dragon_curve_point_core.sv]
`timescale 1ns / 1ps
// Top level of the dragon curve point core: entry stage, level cell chain and result register.
// A request is registered in the entry stage, walks the level cells and is stored in the result register for pos_valid.
// Only one request is in flight: the walk crosses one level cell per cycle while the chain is not stalled
// through a chain of LEVELS - 1 cells, and the next request enters once the result is stored.
// The level table is constant logic built at elaboration and is not touched by reset.
// Reset clears the busy flag, the result valid flag and all stage valid bits; no request is invented.
module dragon_curve_point_core #(
	parameter int LEVELS = dcp_pkg::DCP_LEVELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step_valid,
	output logic                               step_stall,
	input  logic [dcp_pkg::CNT_W-1:0]          step_count,
	output logic                               pos_valid,
	input  logic                               pos_stall,
	output logic signed [dcp_pkg::COORD_W-1:0] pos_x,
	output logic signed [dcp_pkg::COORD_W-1:0] pos_y,
	output logic                               bad_count
);
	import dcp_pkg::*;

	logic [LEVELS-1:0] vld;
	dcp_walk_t         st [LEVELS];
	dcp_walk_t         entry_nxt;
	dcp_walk_t         entry_q;
	logic              entry_valid_q;
	logic              busy_q;
	logic              pos_valid_q;
	logic [COORD_W-1:0] pos_x_q;
	logic [COORD_W-1:0] pos_y_q;
	logic              bad_q;
	logic              accept;
	logic              adv;
	logic              load;
	logic              is_bad;

	assign accept = step_valid && !step_stall;
	assign adv    = !(vld[LEVELS-1] && pos_valid_q && pos_stall);
	assign load   = vld[LEVELS-1] && (!pos_valid_q || !pos_stall);

	assign is_bad = (step_count == '0) ||
		(CMP_W'(step_count) > (CMP_W'(1) << (LEVELS - 1)));

	always_comb begin
		entry_nxt.n    = step_count - CNT_W'(1);
		entry_nxt.x    = '0;
		entry_nxt.y    = COORD_W'(1);
		entry_nxt.d    = 2'd0;
		entry_nxt.in_b = 1'b0;
		entry_nxt.done = is_bad;
		entry_nxt.bad  = is_bad;
		if (is_bad) begin
			entry_nxt.y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
			busy_q        <= 1'b0;
			pos_valid_q   <= 1'b0;
		end else begin
			if (adv) begin
				entry_valid_q <= accept;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				pos_valid_q <= 1'b1;
			end else if (!pos_stall) begin
				pos_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			entry_q <= entry_nxt;
		end
		if (load) begin
			pos_x_q <= st[LEVELS-1].x;
			pos_y_q <= st[LEVELS-1].y;
			bad_q   <= st[LEVELS-1].bad;
		end
	end

	assign vld[0] = entry_valid_q;
	assign st[0]  = entry_q;

	for (genvar j = 1; j < LEVELS; j++) begin : g_cell
		dcp_cell #(
			.LEVEL(LEVELS - j)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.prev_valid(vld[j-1]),
			.prev_walk (st[j-1]),
			.walk_valid(vld[j]),
			.walk      (st[j])
		);
	end

	assign step_stall = busy_q;
	assign pos_valid  = pos_valid_q;
	assign pos_x      = $signed(pos_x_q);
	assign pos_y      = $signed(pos_y_q);
	assign bad_count  = bad_q;

`ifndef SYNTHESIS
	a_one_walk: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(vld))
		else $error("More than one request is in the level chain.");
	a_chain_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(vld != '0) |-> busy_q)
		else $error("A request travels the chain while the core reports idle.");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_valid && bad_count) |-> (pos_x == '0 && pos_y == '0))
		else $error("A rejected step count produced nonzero coordinates.");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pos_valid) |-> $past(busy_q))
		else $error("A result appeared without a request in flight.");
`endif

endmodule

[hw/rtl/dcp_cell.sv]
`timescale 1ns / 1ps
// One level cell of the descent chain: resolves a single table level per cycle while adv is high.
module dcp_cell #(
	parameter int LEVEL = dcp_pkg::DCP_LEVELS_DEF - 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              prev_valid,
	input  dcp_pkg::dcp_walk_t prev_walk,
	output logic              walk_valid,
	output dcp_pkg::dcp_walk_t walk
);
	import dcp_pkg::*;

	localparam dcp_lvl_t       LH    = dcp_level(LEVEL);
	localparam dcp_lvl_t       LK    = dcp_level(LEVEL - 1);
	localparam logic [CMP_W-1:0] CNT_H = (CMP_W'(1) << LEVEL) - CMP_W'(1);
	localparam logic [CMP_W-1:0] POW_K = CMP_W'(1) << (LEVEL - 1);
	localparam logic [CMP_W-1:0] CNT_K = POW_K - CMP_W'(1);
	localparam dcp_vec_t       A_K1  = '{x: LK.a.x, y: LK.a.y + COORD_W'(1)};

	dcp_walk_t          nxt;
	dcp_walk_t          walk_q;
	logic               valid_q;
	logic [CMP_W-1:0]   n_ext;
	logic [CMP_W-1:0]   sub;
	logic [CMP_W-1:0]   diff;
	dcp_vec_t           vec;
	dcp_vec_t           rv;
	logic [1:0]         rot_d;
	logic [1:0]         d_turn;

	assign n_ext  = CMP_W'(prev_walk.n);
	assign d_turn = prev_walk.d + 2'd3;

	always_comb begin
		nxt   = prev_walk;
		vec   = '0;
		sub   = '0;
		rot_d = prev_walk.d;
		if (!prev_walk.done && prev_walk.n != '0) begin
			if (n_ext == CNT_H) begin
				vec      = prev_walk.in_b ? LH.b : LH.a;
				nxt.d    = prev_walk.d + (prev_walk.in_b ? LH.bd : LH.ad);
				nxt.done = 1'b1;
			end else if (!prev_walk.in_b) begin
				if (n_ext >= CNT_K) begin
					sub      = CNT_K;
					vec      = LK.a;
					nxt.d    = prev_walk.d + LK.ad + 2'd1;
					nxt.in_b = 1'b1;
				end
			end else begin
				rot_d = d_turn;
				nxt.d = d_turn;
				if (n_ext == CMP_W'(1)) begin
					vec      = UNIT_VEC;
					sub      = CMP_W'(1);
					nxt.done = 1'b1;
				end else if (n_ext < POW_K) begin
					vec      = UNIT_VEC;
					sub      = CMP_W'(1);
					nxt.in_b = 1'b0;
				end else begin
					vec   = A_K1;
					sub   = POW_K;
					nxt.d = d_turn + LK.ad + 2'd3;
				end
			end
		end
		rv    = dcp_rot(vec, rot_d);
		nxt.x = prev_walk.x + rv.x;
		nxt.y = prev_walk.y + rv.y;
		diff  = n_ext - sub;
		nxt.n = diff[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			walk_q <= nxt;
		end
	end

	assign walk_valid = valid_q;
	assign walk       = walk_q;

endmodule
